// ===== hdl/assert_macros.svh =====
// assertion macros shared by the weighted link table rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WLT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define WLT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/wlt_pkg.sv =====
// types, constants and helpers for the weighted link table
// no dependencies; used by the interfaces, wlt_core and weighted_link_table
package wlt_pkg;

  localparam int NUM_PARTICLES = 1024;
  localparam int SLOTS         = 16;
  localparam int PID_W         = 10;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int CNT_W         = $clog2(SLOTS + 1);
  localparam int WT_W          = 6;
  localparam int WMAX          = 63;
  localparam int ENDS_W        = $clog2(WMAX * SLOTS + 1) + 1;
  localparam int TOT_W         = 14;
  localparam int ADDR_W        = PID_W + SLOT_W;

  localparam logic [2:0] NC_RESET    = 3'd4;
  localparam logic [3:0] TOL_RESET   = 4'd2;
  localparam logic       MULTI_RESET = 1'b0;

  localparam logic [1:0] CFG_NC    = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_MULTI = 2'd2;

  typedef logic [PID_W-1:0]  pid_t;
  typedef logic [WT_W-1:0]   wt_t;
  typedef logic [ENDS_W-1:0] ends_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_REM = 2'd1,
    KIND_QRY = 2'd2,
    KIND_CLR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] nc;
    logic [3:0] tol;
    logic       multi;
  } cfg_t;

  typedef struct packed {
    kind_t kind;
    pid_t  p;
    pid_t  q;
    pid_t  r;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [5:0]       ends_particle;
    logic [5:0]       ends_partner;
    logic [5:0]       ends_new;
    logic             linked;
    logic             attach_ok;
    logic             move_ok;
    logic             detach_ok;
    logic [TOT_W-1:0] total_links;
  } res_t;

  typedef struct packed {
    logic idle;
    logic clearing;
  } eng_stat_t;

  function automatic logic [5:0] sat6(input ends_t v);
    return (v > ENDS_W'(WMAX)) ? 6'(WMAX) : v[5:0];
  endfunction

endpackage

// ===== hdl/wlt_ifs.sv =====
// request and result channel interfaces of the weighted link table
// depends on wlt_pkg
interface wlt_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  wlt_pkg::pid_t    particle;
  wlt_pkg::pid_t    partner;
  wlt_pkg::pid_t    new_partner;

  modport source (output valid, kind, particle, partner, new_partner, input ready);
  modport sink   (input valid, kind, particle, partner, new_partner, output ready);
endinterface

interface wlt_out_if;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [5:0]       ends_particle;
  logic [5:0]       ends_partner;
  logic [5:0]       ends_new;
  logic             linked;
  logic             attach_ok;
  logic             move_ok;
  logic             detach_ok;
  logic [13:0]      total_links;

  modport source (output valid, status, ends_particle, ends_partner, ends_new, linked,
                  attach_ok, move_ok, detach_ok, total_links, input ready);
  modport sink   (input valid, status, ends_particle, ends_partner, ends_new, linked,
                  attach_ok, move_ok, detach_ok, total_links, output ready);
endinterface

// ===== hdl/wlt_core.sv =====
// link table engine: slot and count memories with the sequencer that walks them
// depends on wlt_pkg
module wlt_core (
  input  logic                clk,
  input  logic                rst_n,
  input  wlt_pkg::cfg_t       cfg,
  input  logic                req_valid,
  input  wlt_pkg::req_t       req,
  input  logic                res_free,
  output logic                res_valid,
  output wlt_pkg::res_t       res,
  output wlt_pkg::eng_stat_t  stat
);
  import wlt_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CNT, S_SCAN, S_EVAL, S_SELF, S_SIDE, S_SHIFT, S_DONE
  } state_t;

  // memories
  logic [PID_W+WT_W-1:0] slot_mem [NUM_PARTICLES*SLOTS];
  logic [CNT_W-1:0]      cnt_mem  [NUM_PARTICLES];

  logic                  slot_we;
  logic [ADDR_W-1:0]     slot_wa, slot_ra;
  logic [PID_W+WT_W-1:0] slot_wd, slot_rd_r;
  logic                  cnt_we;
  pid_t                  cnt_wa, cnt_ra;
  logic [CNT_W-1:0]      cnt_wd, cnt_rd_r;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_r <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[cnt_ra];
  end

  // sequencer state
  state_t           state_r;
  pid_t             clr_i_r;
  logic [2:0]       clr_nc_r;
  logic             clr_item_r;
  logic [TOT_W-1:0] tot_r;
  kind_t            kind_r;
  pid_t             p_r, q_r, r_r;
  logic [1:0]       ph_r;
  logic [1:0]       sel_r;
  logic [CNT_W-1:0] cnt_r [3];
  logic [CNT_W-1:0] j_r;
  logic [SLOT_W-1:0] jd_r;
  logic             rdv_r;
  ends_t            sum_r [3];
  wt_t              self_r, w_hp_r, w_hq_r;
  logic [SLOT_W-1:0] hp_r, hq_r;
  logic             fpq_r, fpr_r, fqp_r, frp_r;
  status_t          status_r;
  logic             ok_r;
  logic             lk_r, att_r, mov_r, det_r;
  logic             side_r;
  logic             tog_r;

  // scan helpers
  logic [CNT_W-1:0] cnt_cur;
  pid_t             scan_pid;
  pid_t             rd_pt;
  wt_t              rd_w;

  assign cnt_cur  = cnt_r[sel_r];
  assign scan_pid = (sel_r == 2'd0) ? p_r : ((sel_r == 2'd1) ? q_r : r_r);
  assign rd_pt    = slot_rd_r[PID_W+WT_W-1:WT_W];
  assign rd_w     = slot_rd_r[WT_W-1:0];

  // per-side update helpers
  pid_t              side_pid, side_other;
  logic              side_f;
  logic [SLOT_W-1:0] side_k;
  wt_t               side_w;
  logic [CNT_W-1:0]  side_n;
  logic              side_shift;
  logic              shift_last;
  logic [CNT_W-1:0]  k_plus1;
  wt_t               self_new;
  wt_t               clr_self;

  assign side_pid   = side_r ? q_r : p_r;
  assign side_other = side_r ? p_r : q_r;
  assign side_f     = side_r ? fqp_r : fpq_r;
  assign side_k     = side_r ? hq_r : hp_r;
  assign side_w     = side_r ? w_hq_r : w_hp_r;
  assign side_n     = side_r ? cnt_r[1] : cnt_r[0];
  assign k_plus1    = CNT_W'(side_k) + CNT_W'(1);
  assign side_shift = (side_w == WT_W'(1)) && (k_plus1 < side_n);
  assign shift_last = !((j_r + CNT_W'(2)) < side_n);
  assign self_new   = (kind_r == KIND_ADD) ? (self_r - WT_W'(2)) : (self_r + WT_W'(2));
  assign clr_self   = {2'b00, clr_nc_r, 1'b0};

  // evaluation of the scanned item
  status_t          eval_st;
  logic [4:0]       two_nc;
  logic [5:0]       nmax;
  logic             gt_min_p, gt_min_q, lt_max_p, lt_max_k;
  logic             single;

  assign two_nc   = {1'b0, cfg.nc, 1'b0};
  assign nmax     = 6'(two_nc) + 6'(cfg.tol);
  assign gt_min_p = (ENDS_W'(sum_r[0]) + ENDS_W'(cfg.tol)) > ENDS_W'(two_nc);
  assign gt_min_q = (ENDS_W'(sum_r[1]) + ENDS_W'(cfg.tol)) > ENDS_W'(two_nc);
  assign lt_max_p = sum_r[0] < ENDS_W'(nmax);
  assign lt_max_k = sum_r[2] < ENDS_W'(nmax);
  assign single   = !cfg.multi;

  always_comb begin
    eval_st = ST_OK;
    case (kind_r)
      KIND_ADD: begin
        if ((p_r == q_r) || (self_r < WT_W'(2))) begin
          eval_st = ST_INVALID;
        end else if ((!fpq_r && (cnt_r[0] >= CNT_W'(SLOTS))) ||
                     (!fqp_r && (cnt_r[1] >= CNT_W'(SLOTS))) ||
                     (fpq_r && (w_hp_r >= WT_W'(WMAX))) ||
                     (fqp_r && (w_hq_r >= WT_W'(WMAX)))) begin
          eval_st = ST_FULL;
        end
      end
      KIND_REM: begin
        if (!fpq_r || !fqp_r) begin
          eval_st = ST_MISSING;
        end else if (self_r > WT_W'(WMAX - 2)) begin
          eval_st = ST_FULL;
        end
      end
      default: eval_st = ST_OK;
    endcase
  end

  // memory port control
  always_comb begin
    slot_we = 1'b0;
    slot_wa = '0;
    slot_wd = '0;
    slot_ra = {scan_pid, j_r[SLOT_W-1:0]};
    cnt_we  = 1'b0;
    cnt_wa  = side_pid;
    cnt_wd  = '0;
    cnt_ra  = p_r;
    case (state_r)
      S_CLR: begin
        slot_we = 1'b1;
        slot_wa = {clr_i_r, SLOT_W'(0)};
        slot_wd = {clr_i_r, clr_self};
        cnt_we  = 1'b1;
        cnt_wa  = clr_i_r;
        cnt_wd  = CNT_W'(1);
      end
      S_CNT: begin
        cnt_ra = (ph_r == 2'd0) ? p_r : ((ph_r == 2'd1) ? q_r : r_r);
      end
      S_SELF: begin
        slot_we = 1'b1;
        slot_wa = {p_r, SLOT_W'(0)};
        slot_wd = {p_r, self_new};
      end
      S_SIDE: begin
        if (kind_r == KIND_ADD) begin
          slot_we = 1'b1;
          if (!side_f) begin
            slot_wa = {side_pid, side_n[SLOT_W-1:0]};
            slot_wd = {side_other, WT_W'(1)};
            cnt_we  = 1'b1;
            cnt_wd  = side_n + CNT_W'(1);
          end else begin
            slot_wa = {side_pid, side_k};
            slot_wd = {side_other, side_w + WT_W'(1)};
          end
        end else if (side_w != WT_W'(1)) begin
          slot_we = 1'b1;
          slot_wa = {side_pid, side_k};
          slot_wd = {side_other, side_w - WT_W'(1)};
        end else if (!side_shift) begin
          cnt_we = 1'b1;
          cnt_wd = side_n - CNT_W'(1);
        end
      end
      S_SHIFT: begin
        slot_ra = {side_pid, SLOT_W'(j_r + CNT_W'(1))};
        if (tog_r) begin
          slot_we = 1'b1;
          slot_wa = {side_pid, j_r[SLOT_W-1:0]};
          slot_wd = slot_rd_r;
          if (shift_last) begin
            cnt_we = 1'b1;
            cnt_wd = side_n - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_i_r    <= '0;
      clr_nc_r   <= NC_RESET;
      clr_item_r <= 1'b0;
      tot_r      <= '0;
      rdv_r      <= 1'b0;
    end else begin
      case (state_r)
        S_CLR: begin
          if (clr_i_r == PID_W'(NUM_PARTICLES - 1)) begin
            state_r <= clr_item_r ? S_DONE : S_IDLE;
          end
          clr_i_r <= clr_i_r + PID_W'(1);
        end
        S_IDLE: begin
          if (req_valid) begin
            kind_r <= req.kind;
            p_r    <= req.p;
            q_r    <= req.q;
            r_r    <= req.r;
            if (req.kind == KIND_CLR) begin
              clr_nc_r   <= cfg.nc;
              clr_item_r <= 1'b1;
              clr_i_r    <= '0;
              tot_r      <= '0;
              state_r    <= S_CLR;
            end else begin
              ph_r     <= 2'd0;
              sel_r    <= 2'd0;
              j_r      <= '0;
              rdv_r    <= 1'b0;
              sum_r[0] <= '0;
              sum_r[1] <= '0;
              sum_r[2] <= '0;
              fpq_r    <= 1'b0;
              fpr_r    <= 1'b0;
              fqp_r    <= 1'b0;
              frp_r    <= 1'b0;
              state_r  <= S_CNT;
            end
          end
        end
        S_CNT: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd1) cnt_r[0] <= cnt_rd_r;
          if (ph_r == 2'd2) cnt_r[1] <= cnt_rd_r;
          if (ph_r == 2'd3) begin
            cnt_r[2] <= cnt_rd_r;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rdv_r) begin
            sum_r[sel_r] <= sum_r[sel_r] + ENDS_W'(rd_w);
            if (jd_r == '0) begin
              if (sel_r == 2'd0) self_r <= rd_w;
            end else begin
              case (sel_r)
                2'd0: begin
                  if (rd_pt == q_r && !fpq_r) begin
                    fpq_r  <= 1'b1;
                    hp_r   <= jd_r;
                    w_hp_r <= rd_w;
                  end
                  if (rd_pt == r_r) fpr_r <= 1'b1;
                end
                2'd1: begin
                  if (rd_pt == p_r && !fqp_r) begin
                    fqp_r  <= 1'b1;
                    hq_r   <= jd_r;
                    w_hq_r <= rd_w;
                  end
                end
                default: begin
                  if (rd_pt == p_r) frp_r <= 1'b1;
                end
              endcase
            end
          end
          if (j_r < cnt_cur) begin
            j_r   <= j_r + CNT_W'(1);
            jd_r  <= j_r[SLOT_W-1:0];
            rdv_r <= 1'b1;
          end else begin
            rdv_r <= 1'b0;
            if (!rdv_r) begin
              j_r <= '0;
              if (sel_r == 2'd2) state_r <= S_EVAL;
              else sel_r <= sel_r + 2'd1;
            end
          end
        end
        S_EVAL: begin
          status_r <= eval_st;
          ok_r     <= (eval_st == ST_OK) && (kind_r == KIND_ADD || kind_r == KIND_REM);
          lk_r     <= 1'b0;
          att_r    <= 1'b0;
          mov_r    <= 1'b0;
          det_r    <= 1'b0;
          if (kind_r == KIND_QRY) begin
            lk_r  <= fpr_r && frp_r;
            att_r <= (r_r != p_r) && (q_r == p_r) && gt_min_p && lt_max_k &&
                     !(single && fpr_r && frp_r);
            mov_r <= (r_r != q_r) && (q_r != p_r) && gt_min_q && lt_max_k &&
                     !(single && fpr_r && frp_r);
            det_r <= (r_r == p_r) && (q_r != p_r) && lt_max_p && gt_min_q;
          end
          if ((eval_st == ST_OK) && (kind_r == KIND_ADD || kind_r == KIND_REM)) begin
            state_r <= S_SELF;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SELF: begin
          if (kind_r == KIND_ADD) tot_r <= tot_r + TOT_W'(1);
          else if (tot_r != '0) tot_r <= tot_r - TOT_W'(1);
          side_r  <= 1'b0;
          state_r <= S_SIDE;
        end
        S_SIDE: begin
          if (kind_r == KIND_REM && side_shift) begin
            j_r     <= CNT_W'(side_k);
            tog_r   <= 1'b0;
            state_r <= S_SHIFT;
          end else if (!side_r) begin
            side_r <= 1'b1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SHIFT: begin
          tog_r <= !tog_r;
          if (tog_r) begin
            if (shift_last) begin
              if (!side_r) begin
                side_r  <= 1'b1;
                state_r <= S_SIDE;
              end else begin
                state_r <= S_DONE;
              end
            end else begin
              j_r <= j_r + CNT_W'(1);
            end
          end
        end
        S_DONE: begin
          if (res_free) begin
            clr_item_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result assembly
  ends_t ep, eq, er;

  always_comb begin
    ep = sum_r[0];
    eq = sum_r[1];
    if (ok_r && kind_r == KIND_ADD) begin
      ep = sum_r[0] - ENDS_W'(1);
      eq = sum_r[1] + ENDS_W'(1);
    end else if (ok_r && kind_r == KIND_REM) begin
      ep = sum_r[0] + ENDS_W'(1);
      eq = sum_r[1] - ENDS_W'(1);
    end
    er = (r_r == p_r) ? ep : ((r_r == q_r) ? eq : sum_r[2]);
  end

  always_comb begin
    res.total_links = tot_r;
    if (kind_r == KIND_CLR) begin
      res.status        = ST_OK;
      res.ends_particle = 6'(clr_self);
      res.ends_partner  = 6'(clr_self);
      res.ends_new      = 6'(clr_self);
      res.linked        = 1'b0;
      res.attach_ok     = 1'b0;
      res.move_ok       = 1'b0;
      res.detach_ok     = 1'b0;
    end else begin
      res.status        = status_r;
      res.ends_particle = sat6(ep);
      res.ends_partner  = sat6(eq);
      res.ends_new      = sat6(er);
      res.linked        = lk_r;
      res.attach_ok     = att_r;
      res.move_ok       = mov_r;
      res.detach_ok     = det_r;
    end
  end

  assign res_valid     = (state_r == S_DONE) && res_free;
  assign stat.idle     = (state_r == S_IDLE);
  assign stat.clearing = (state_r == S_CLR);

endmodule

// ===== hdl/weighted_link_table.sv =====
// weighted link table: after acceptance the engine reads the slot counts of the three particles,
// scans their slots in use and evaluates the request; a query or a refused request then gives its result
// a completed add or remove also writes the self weight and both sides, and a remove moves slots up
// clear walks 1024 particles, one a cycle, before it gives its result
// one request at a time: the next is taken the cycle after the engine hands its result over
// after reset a clearing pass over the 1024 particles runs before the first request is taken
`include "assert_macros.svh"

module weighted_link_table (
  input  logic         clk,
  input  logic         rst_n,
  wlt_in_if.sink       in_req,
  wlt_out_if.source    out_res,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [3:0]   cfg_data
);
  import wlt_pkg::*;

  // configuration registers: the user writes them only while the block is idle; the block does not enforce this
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nc    <= NC_RESET;
      cfg_r.tol   <= TOL_RESET;
      cfg_r.multi <= MULTI_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NC:    cfg_r.nc    <= cfg_data[2:0];
        CFG_TOL:   cfg_r.tol   <= cfg_data;
        CFG_MULTI: cfg_r.multi <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request payload into the engine
  req_t      req;
  res_t      res;
  logic      res_valid;
  logic      res_free;
  eng_stat_t eng_stat;

  assign req.kind = kind_t'(in_req.kind);
  assign req.p    = in_req.particle;
  assign req.q    = in_req.partner;
  assign req.r    = in_req.new_partner;

  // a request is taken only while the engine sits idle
  assign in_req.ready = eng_stat.idle;

  wlt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_req.valid),
    .req       (req),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .stat      (eng_stat)
  );

  // output register: the engine hands over only when the slot is free
  logic out_valid_r;
  res_t out_res_r;

  assign res_free = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = out_res_r.status;
  assign out_res.ends_particle = out_res_r.ends_particle;
  assign out_res.ends_partner  = out_res_r.ends_partner;
  assign out_res.ends_new      = out_res_r.ends_new;
  assign out_res.linked        = out_res_r.linked;
  assign out_res.attach_ok     = out_res_r.attach_ok;
  assign out_res.move_ok       = out_res_r.move_ok;
  assign out_res.detach_ok     = out_res_r.detach_ok;
  assign out_res.total_links   = out_res_r.total_links;

  // checks
  `WLT_ASSERT_IMP(a_no_req_while_clearing, clk, rst_n, eng_stat.clearing, !in_req.ready)
  `WLT_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_req.valid && in_req.ready, !eng_stat.idle)
  `WLT_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, res_valid, !out_valid_r || out_res.ready)

endmodule

// ===== tb/sv/tb_wlt_ifs.sv =====
// note: the channel interfaces are defined by the rtl file hdl/wlt_ifs.sv
// this file holds only the small helper package the testbench needs
// depends on wlt_pkg
package tb_wlt_pkg;
  import wlt_pkg::*;

  // one request with its expected result, kept for mismatch reports
  typedef struct {
    kind_t kind;
    pid_t  p;
    pid_t  q;
    pid_t  r;
    res_t  res;
  } link_expect_t;
endpackage

// ===== tb/sv/tb_weighted_link_table.sv =====
// self-checking testbench for weighted_link_table: a behavioural copy of the link
// table predicts each result, which is compared field by field with the block's output
// depends on wlt_pkg, tb_wlt_pkg and the wlt_in_if / wlt_out_if interfaces
module tb_weighted_link_table;
  import wlt_pkg::*;
  import tb_wlt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_NC;
  logic [3:0] cfg_data = '0;

  wlt_in_if  in_req();
  wlt_out_if out_res();

  weighted_link_table DUT (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state: one copy of the table and of the registers
  int unsigned tbl_partner [NUM_PARTICLES][SLOTS];
  int unsigned tbl_weight  [NUM_PARTICLES][SLOTS];
  int unsigned tbl_used    [NUM_PARTICLES];
  int unsigned tbl_links;
  int unsigned reg_nc, reg_tol, reg_multi;

  link_expect_t pending_results[$];
  int unsigned mismatches, results_seen, requests_sent;
  int unsigned n_add_ok, n_rem_ok, n_query;

  // rebuild the table from the current chains register
  function automatic void table_clear();
    for (int i = 0; i < NUM_PARTICLES; i++) begin
      for (int s = 0; s < SLOTS; s++) begin
        tbl_partner[i][s] = 0;
        tbl_weight[i][s]  = 0;
      end
      tbl_partner[i][0] = i;
      tbl_weight[i][0]  = (2 * reg_nc) & 63;
      tbl_used[i]       = 1;
    end
    tbl_links = 0;
  endfunction

  // slot of b in a's list, or the count when absent
  function automatic int unsigned slot_of(int unsigned a, int unsigned b);
    for (int unsigned i = 1; i < tbl_used[a] && i < SLOTS; i++)
      if (tbl_partner[a][i] == b) return i;
    return tbl_used[a];
  endfunction

  function automatic int unsigned ends_sum(int unsigned a);
    int unsigned s;
    s = 0;
    for (int unsigned i = 0; i < tbl_used[a] && i < SLOTS; i++) s += tbl_weight[a][i];
    return s;
  endfunction

  function automatic logic [5:0] ends_clip(int unsigned a);
    int unsigned s;
    s = ends_sum(a);
    return (s > 63) ? 6'd63 : s[5:0];
  endfunction

  function automatic void slot_bump(int unsigned a, int unsigned other, int unsigned k);
    if (k == tbl_used[a]) begin
      tbl_partner[a][k] = other;
      tbl_weight[a][k]  = 1;
      tbl_used[a]       = k + 1;
    end else begin
      tbl_weight[a][k]++;
    end
  endfunction

  // take one off a slot and close the list up when it empties
  function automatic void slot_drop(int unsigned a, int unsigned k);
    int unsigned n;
    n = tbl_used[a];
    if (tbl_weight[a][k] > 0) tbl_weight[a][k]--;
    if (tbl_weight[a][k] == 0) begin
      for (int unsigned j = k; j + 1 < n; j++) begin
        tbl_partner[a][j] = tbl_partner[a][j+1];
        tbl_weight[a][j]  = tbl_weight[a][j+1];
      end
      tbl_partner[a][n-1] = 0;
      tbl_weight[a][n-1]  = 0;
      tbl_used[a]         = n - 1;
    end
  endfunction

  // work out the result of one request and update the table copy
  function automatic res_t link_predict(kind_t kind, int unsigned p, int unsigned q,
                                        int unsigned r);
    res_t res;
    int unsigned hp, hq;
    int nmin, nmax, ei, ej, ek;
    logic lk, single;
    res = '0;
    res.status = ST_OK;
    if (kind == KIND_CLR) begin
      table_clear();
    end else if (kind == KIND_ADD) begin
      if (p == q || tbl_weight[p][0] < 2) begin
        res.status = ST_INVALID;
      end else begin
        hp = slot_of(p, q);
        hq = slot_of(q, p);
        if ((hp == tbl_used[p] && tbl_used[p] >= SLOTS) ||
            (hq == tbl_used[q] && tbl_used[q] >= SLOTS) ||
            (hp < tbl_used[p] && tbl_weight[p][hp] >= 63) ||
            (hq < tbl_used[q] && tbl_weight[q][hq] >= 63)) begin
          res.status = ST_FULL;
        end else begin
          tbl_weight[p][0] -= 2;
          slot_bump(p, q, hp);
          slot_bump(q, p, hq);
          tbl_links = (tbl_links + 1) & 16'h3FFF;
          n_add_ok++;
        end
      end
    end else if (kind == KIND_REM) begin
      hp = slot_of(p, q);
      hq = slot_of(q, p);
      if (hp == tbl_used[p] || hq == tbl_used[q]) begin
        res.status = ST_MISSING;
      end else if (tbl_weight[p][0] > 61) begin
        res.status = ST_FULL;
      end else begin
        slot_drop(p, hp);
        slot_drop(q, hq);
        tbl_weight[p][0] += 2;
        if (tbl_links > 0) tbl_links--;
        n_rem_ok++;
      end
    end else begin
      n_query++;
      nmin = 2 * int'(reg_nc) - int'(reg_tol);
      nmax = 2 * int'(reg_nc) + int'(reg_tol);
      ei = ends_sum(p);
      ej = ends_sum(q);
      ek = ends_sum(r);
      single = (reg_multi == 0);
      lk = (slot_of(p, r) != tbl_used[p]) && (slot_of(r, p) != tbl_used[r]);
      res.linked    = lk;
      res.attach_ok = (r != p && q == p && ei > nmin && ek < nmax && !(single && lk));
      res.move_ok   = (r != q && q != p && ej > nmin && ek < nmax && !(single && lk));
      res.detach_ok = (r == p && q != p && ei < nmax && ej > nmin);
    end
    // all indices of a 10-bit field are in range with 1024 particles
    res.ends_particle = ends_clip(p);
    res.ends_partner  = ends_clip(q);
    res.ends_new      = ends_clip(r);
    res.total_links   = tbl_links[13:0];
    return res;
  endfunction

  // idle gap: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned x;
    x = $urandom_range(0, 99);
    if (x < 50) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  logic stall_free = 1'b0;

  // send one request and queue its expectation at the handshake
  // valid stays high after acceptance so a following request can go back to back
  task automatic send_request(kind_t kind, pid_t p, pid_t q, pid_t r);
    link_expect_t e;
    int unsigned g;
    g = stall_free ? 0 : gap_len();
    if (g != 0) begin
      in_req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.kind        <= kind;
    in_req.particle    <= p;
    in_req.partner     <= q;
    in_req.new_partner <= r;
    do @(posedge clk); while (!in_req.ready);
    e.kind = kind; e.p = p; e.q = q; e.r = r;
    e.res = link_predict(kind, p, q, r);
    pending_results.push_back(e);
    requests_sent++;
  endtask

  // result side: random stalls, compare at each accepted result
  initial begin
    out_res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_res.valid && out_res.ready) begin
        res_t got;
        link_expect_t e;
        got.status        = status_t'(out_res.status);
        got.ends_particle = out_res.ends_particle;
        got.ends_partner  = out_res.ends_partner;
        got.ends_new      = out_res.ends_new;
        got.linked        = out_res.linked;
        got.attach_ok     = out_res.attach_ok;
        got.move_ok       = out_res.move_ok;
        got.detach_ok     = out_res.detach_ok;
        got.total_links   = out_res.total_links;
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          e = pending_results.pop_front();
          if (got !== e.res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch kind %s p %0d q %0d r %0d: expected %p, got %p",
                       e.kind.name(), e.p, e.q, e.r, e.res, got);
          end
        end
      end
      // stalls on the result side
      out_res.ready <= stall_free ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // wait for every result, then a margin for a clear still in flight
  task automatic drain();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NC:  reg_nc    = val & 7;
      CFG_TOL: reg_tol   = val & 15;
      default: reg_multi = val & 1;
    endcase
  endtask

  task automatic set_regs(int unsigned nc, int unsigned tol, int unsigned multi);
    drain();
    write_reg(CFG_NC, nc);
    write_reg(CFG_TOL, tol);
    write_reg(CFG_MULTI, multi);
    @(posedge clk);
  endtask

  // directed: field extremes, every kind and the error cases
  task automatic test_directed();
    send_request(KIND_QRY, 10'd0, 10'd0, 10'd1023);
    send_request(KIND_ADD, 10'd5, 10'd5, 10'd0);            // self pair
    send_request(KIND_REM, 10'd5, 10'd6, 10'd0);            // missing link
    send_request(KIND_REM, 10'd7, 10'd7, 10'd0);            // self pair remove
    send_request(KIND_ADD, 10'd0, 10'd1023, 10'd0);
    send_request(KIND_ADD, 10'd0, 10'd1023, 10'd0);         // duplicate is allowed
    send_request(KIND_QRY, 10'd0, 10'd0, 10'd1023);         // linked, single mode
    send_request(KIND_QRY, 10'd1023, 10'd0, 10'd1023);      // detach shape
    send_request(KIND_QRY, 10'd0, 10'd1023, 10'd512);       // move shape
    for (int i = 0; i < 4; i++)                             // drain self weight
      send_request(KIND_ADD, 10'd0, pid_t'(100 + i), 10'd0);
    send_request(KIND_ADD, 10'd0, 10'd200, 10'd0);          // self weight too low
    send_request(KIND_REM, 10'd0, 10'd1023, 10'd0);
    send_request(KIND_REM, 10'd0, 10'd1023, 10'd0);         // slot compacts
    send_request(KIND_REM, 10'd0, 10'd1023, 10'd0);         // now missing
    send_request(KIND_CLR, 10'h3FF, 10'h3FF, 10'h3FF);
    send_request(KIND_QRY, 10'h2AA, 10'h155, 10'h2AA);
  endtask

  // slots full: high chains so one particle links to many others
  task automatic test_slots_full();
    set_regs(7, 8, 1);
    send_request(KIND_CLR, 10'd0, 10'd0, 10'd0);
    for (int i = 1; i <= 16; i++)
      send_request(KIND_ADD, pid_t'(300 + i), 10'd300, 10'd0);
    send_request(KIND_QRY, 10'd300, 10'd300, 10'd301);
  endtask

  // self weight at capacity: particle 400 gains two free ends for every
  // removal of a link that another particle made, until it passes 61
  task automatic test_capacity();
    set_regs(7, 0, 1);
    send_request(KIND_CLR, 10'd0, 10'd0, 10'd0);
    for (int i = 0; i < 5; i++) begin
      for (int k = 0; k < 7; k++) send_request(KIND_ADD, pid_t'(410 + i), 10'd400, 10'd0);
      for (int k = 0; k < 7; k++) send_request(KIND_REM, 10'd400, pid_t'(410 + i), 10'd0);
    end
    send_request(KIND_QRY, 10'd400, 10'd400, 10'd401);
  endtask

  // random traffic within a small pool so links build up and meet
  task automatic test_random(int unsigned count, int unsigned pool);
    int unsigned x, base;
    kind_t k;
    pid_t p, q, r;
    base = $urandom_range(0, 1023 - pool);
    for (int unsigned n = 0; n < count; n++) begin
      x = $urandom_range(0, 999);
      p = pid_t'(base + $urandom_range(0, pool - 1));
      q = pid_t'(base + $urandom_range(0, pool - 1));
      r = pid_t'(base + $urandom_range(0, pool - 1));
      if (x < 40) begin                       // full-range noise
        p = pid_t'($urandom); q = pid_t'($urandom); r = pid_t'($urandom);
      end
      if (x < 2)        k = KIND_CLR;
      else if (x < 420) k = KIND_ADD;
      else if (x < 700) k = KIND_REM;
      else              k = KIND_QRY;
      if (k == KIND_QRY && x[0]) q = p;       // attach shape
      if (k == KIND_QRY && x[1] && !x[0]) r = p;
      stall_free = (n % 200) > 170;           // stretches with no idling
      send_request(k, p, q, r);
    end
    stall_free = 1'b0;
  endtask

  initial begin
    in_req.valid = 1'b0;
    in_req.kind = KIND_ADD;
    in_req.particle = '0;
    in_req.partner = '0;
    in_req.new_partner = '0;
    mismatches = 0; results_seen = 0; requests_sent = 0;
    n_add_ok = 0; n_rem_ok = 0; n_query = 0;
    reg_nc = NC_RESET; reg_tol = TOL_RESET; reg_multi = MULTI_RESET;
    table_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_slots_full();
    test_capacity();
    set_regs(1, 0, 0);
    send_request(KIND_CLR, 10'd0, 10'd0, 10'd0);
    test_random(300, 6);
    set_regs(4, 2, 1);
    test_random(400, 12);
    set_regs(7, 8, 0);
    send_request(KIND_CLR, 10'd0, 10'd0, 10'd0);
    test_random(400, 20);
    set_regs(0, 3, 1);
    send_request(KIND_CLR, 10'd0, 10'd0, 10'd0);
    test_random(150, 5);
    drain();
    $display("covered %0d requests: %0d links made, %0d removed, %0d rule queries",
             requests_sent, n_add_ok, n_rem_ok, n_query);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // generous overall limit
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
